// ===== rtl/core/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Types and constants shared by the sphere push-out pipeline.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadiusW = 31;
  localparam int unsigned RangeW  = 32;
  localparam int unsigned SqW     = 64;
  localparam int unsigned LenW    = 32;
  localparam int unsigned SqRemW  = 34;
  localparam int unsigned QuoW    = 34;
  localparam int unsigned SqrtSteps = LenW;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned Lanes     = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [Lanes-1:0][CoordW-1:0] vec_t;

  typedef struct packed {
    logic                      hit;
    logic                      zero;
    logic [Lanes-1:0]          neg;
    vec_t                      a;
    vec_t                      b;
    logic [Lanes-1:0][SqW-1:0] prod;
  } side_t;

  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [SqW-1:0]    rad;
    logic [SqRemW-1:0] rem;
    logic [LenW-1:0]   root;
  } sqrt_beat_t;

  typedef struct packed {
    logic                       valid;
    logic                       hit;
    logic                       zero;
    logic [Lanes-1:0]           neg;
    vec_t                       a;
    vec_t                       b;
    logic [LenW-1:0]            len;
    logic [Lanes-1:0][QuoW-1:0] numr;
    logic [Lanes-1:0][LenW-1:0] rem;
    logic [Lanes-1:0][QuoW-1:0] quo;
  } div_beat_t;

endpackage

// ===== rtl/core/ssp_front.sv =====
// ----------------------------------------------------------------------------
// ssp_front
// Difference, squares, hit compare and push-out products in three stages.
// ----------------------------------------------------------------------------
module ssp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  ssp_pkg::vec_t             a_i,
  input  ssp_pkg::vec_t             b_i,
  input  logic [ssp_pkg::RadiusW-1:0] radius_a_i,
  input  logic [ssp_pkg::RadiusW-1:0] radius_b_i,
  output ssp_pkg::sqrt_beat_t       beat_o
);
  import ssp_pkg::*;

  logic                          v1_q, v2_q, v3_q;
  logic [Lanes-1:0][CoordW:0]    d1_q;
  logic [RangeW-1:0]             r1_q, r2_q;
  vec_t                          a1_q, b1_q, a2_q, b2_q;
  logic [Lanes-1:0][CoordW-1:0]  mag2_q;
  logic [Lanes-1:0][SqW-1:0]     sq2_q;
  logic [SqW-1:0]                rsq2_q;
  logic [Lanes-1:0]              neg2_q;
  side_t                         side3_q;
  logic [SqW-1:0]                rad3_q;

  logic [Lanes-1:0][CoordW:0]    d1_d;
  logic [Lanes-1:0][CoordW-1:0]  mag2_d;
  logic [Lanes-1:0][SqW-1:0]     sq2_d, prod3_d;
  logic [SqW+1:0]                sum3_d;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      d1_d[i] = {b_i[i][CoordW-1], b_i[i]} - {a_i[i][CoordW-1], a_i[i]};
      mag2_d[i] = d1_q[i][CoordW] ? CoordW'(-d1_q[i]) : d1_q[i][CoordW-1:0];
      sq2_d[i] = SqW'(mag2_d[i]) * SqW'(mag2_d[i]);
      prod3_d[i] = SqW'(mag2_q[i]) * SqW'(r2_q);
    end
    sum3_d = (SqW+2)'(sq2_q[0]) + (SqW+2)'(sq2_q[1]) + (SqW+2)'(sq2_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q   <= d1_d;
      r1_q   <= RangeW'(radius_a_i) + RangeW'(radius_b_i);
      a1_q   <= a_i;
      b1_q   <= b_i;
      mag2_q <= mag2_d;
      sq2_q  <= sq2_d;
      rsq2_q <= SqW'(r1_q) * SqW'(r1_q);
      r2_q   <= r1_q;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      for (int i = 0; i < Lanes; i++) neg2_q[i] <= d1_q[i][CoordW];
      side3_q.hit  <= sum3_d <= (SqW+2)'(rsq2_q);
      side3_q.zero <= sum3_d == '0;
      side3_q.neg  <= neg2_q;
      side3_q.a    <= a2_q;
      side3_q.b    <= b2_q;
      side3_q.prod <= prod3_d;
      rad3_q       <= sum3_d[SqW-1:0];
    end
  end

  always_comb begin
    beat_o.valid = v3_q;
    beat_o.side  = side3_q;
    beat_o.rad   = rad3_q;
    beat_o.rem   = '0;
    beat_o.root  = '0;
  end

endmodule

// ===== rtl/core/ssp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ssp_sqrt_cell
// One digit of the square root: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module ssp_sqrt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  ssp_pkg::sqrt_beat_t  beat_i,
  output ssp_pkg::sqrt_beat_t  beat_o
);
  import ssp_pkg::*;

  sqrt_beat_t         beat_d, beat_q;
  logic               valid_q;
  logic [SqRemW+1:0]  t, trial;

  always_comb begin
    beat_d = beat_i;
    t      = {beat_i.rem, beat_i.rad[SqW-1 -: 2]};
    trial  = {2'b00, beat_i.root, 2'b01};
    beat_d.rad = {beat_i.rad[SqW-3:0], 2'b00};
    if (t >= trial) begin
      beat_d.rem  = SqRemW'(t - trial);
      beat_d.root = {beat_i.root[LenW-2:0], 1'b1};
    end else begin
      beat_d.rem  = t[SqRemW-1:0];
      beat_d.root = {beat_i.root[LenW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) beat_q <= beat_d;
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/ssp_div_cell.sv =====
// ----------------------------------------------------------------------------
// ssp_div_cell
// One restoring-division step per lane: one quotient bit each.
// ----------------------------------------------------------------------------
module ssp_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ssp_pkg::div_beat_t  beat_i,
  output ssp_pkg::div_beat_t  beat_o
);
  import ssp_pkg::*;

  div_beat_t        beat_d, beat_q;
  logic             valid_q;
  logic [LenW:0]    t;

  always_comb begin
    beat_d = beat_i;
    t      = '0;
    for (int i = 0; i < Lanes; i++) begin
      t = {beat_i.rem[i], beat_i.numr[i][QuoW-1]};
      beat_d.numr[i] = {beat_i.numr[i][QuoW-2:0], 1'b0};
      if (t >= {1'b0, beat_i.len}) begin
        beat_d.rem[i] = LenW'(t - {1'b0, beat_i.len});
        beat_d.quo[i] = {beat_i.quo[i][QuoW-2:0], 1'b1};
      end else begin
        beat_d.rem[i] = t[LenW-1:0];
        beat_d.quo[i] = {beat_i.quo[i][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) beat_q <= beat_d;
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/sphere_sphere_pushout_core.sv =====
// ----------------------------------------------------------------------------
// sphere_sphere_pushout_core
// Pipeline from input beat to output valid: 3 front stages, 32 square-root
// cells, 1 numerator stage, 34 divider cells and 1 output stage.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// register is full and not taken. Reset clears all valid bits only.
// ----------------------------------------------------------------------------
module sphere_sphere_pushout_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [31:0]          a_x_i,
  input  logic signed [31:0]          a_y_i,
  input  logic signed [31:0]          a_z_i,
  input  logic [30:0]                 radius_a_i,
  input  logic signed [31:0]          b_x_i,
  input  logic signed [31:0]          b_y_i,
  input  logic signed [31:0]          b_z_i,
  input  logic [30:0]                 radius_b_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic signed [31:0]          out_x_o,
  output logic signed [31:0]          out_y_o,
  output logic signed [31:0]          out_z_o
);
  import ssp_pkg::*;

  logic        en;
  vec_t        a_in, b_in;
  sqrt_beat_t  sq_beat [SqrtSteps+1];
  div_beat_t   dv_beat [DivSteps+1];
  div_beat_t   num_d, num_q;
  logic        num_valid_q;
  logic        out_valid_q, hit_q;
  vec_t        out_d, out_q;
  logic signed [CoordW+3:0] acc;
  logic [SqW-1:0] numv;
  div_beat_t   last;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign a_in        = {a_z_i, a_y_i, a_x_i};
  assign b_in        = {b_z_i, b_y_i, b_x_i};

  ssp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .a_i        (a_in),
    .b_i        (b_in),
    .radius_a_i (radius_a_i),
    .radius_b_i (radius_b_i),
    .beat_o     (sq_beat[0])
  );

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    ssp_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (sq_beat[k]),
      .beat_o (sq_beat[k+1])
    );
  end

  always_comb begin
    num_d       = '0;
    numv        = '0;
    num_d.hit   = sq_beat[SqrtSteps].side.hit;
    num_d.zero  = sq_beat[SqrtSteps].side.zero;
    num_d.neg   = sq_beat[SqrtSteps].side.neg;
    num_d.a     = sq_beat[SqrtSteps].side.a;
    num_d.b     = sq_beat[SqrtSteps].side.b;
    num_d.len   = sq_beat[SqrtSteps].root;
    for (int i = 0; i < Lanes; i++) begin
      numv = sq_beat[SqrtSteps].side.prod[i] + SqW'(sq_beat[SqrtSteps].root >> 1);
      num_d.rem[i]  = LenW'(numv[SqW-1:QuoW]);
      num_d.numr[i] = numv[QuoW-1:0];
      num_d.quo[i]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_valid_q <= 1'b0;
    end else if (en) begin
      num_valid_q <= sq_beat[SqrtSteps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) num_q <= num_d;
  end

  always_comb begin
    dv_beat[0]       = num_q;
    dv_beat[0].valid = num_valid_q;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    ssp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (dv_beat[k]),
      .beat_o (dv_beat[k+1])
    );
  end

  assign last = dv_beat[DivSteps];

  always_comb begin
    out_d = '0;
    acc   = '0;
    for (int i = 0; i < Lanes; i++) begin
      if (last.neg[i]) begin
        acc = {{4{last.a[i][CoordW-1]}}, last.a[i]} - {2'b00, last.quo[i]};
      end else begin
        acc = {{4{last.a[i][CoordW-1]}}, last.a[i]} + {2'b00, last.quo[i]};
      end
      if (!last.hit) begin
        out_d[i] = last.b[i];
      end else if (last.zero) begin
        out_d[i] = last.a[i];
      end else if (acc > (CoordW+4)'(signed'(32'sh7FFF_FFFF))) begin
        out_d[i] = 32'h7FFF_FFFF;
      end else if (acc < (CoordW+4)'(signed'(32'sh8000_0000))) begin
        out_d[i] = 32'h8000_0000;
      end else begin
        out_d[i] = acc[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
      hit_q <= last.hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];

endmodule

// ===== rtl/core/ssp_checker.sv =====
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks for the sphere push-out core.
// ----------------------------------------------------------------------------
module ssp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic [31:0] out_x_o,
  input logic [31:0] out_y_o,
  input logic [31:0] out_z_o
);

  a_ready_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
    $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o))
    else $error("stalled output beat changed");

  a_reset_empty : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind sphere_sphere_pushout_core ssp_checker u_ssp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hit_o       (hit_o),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o)
);
